// File: rtl/slt_pkg.sv
// Types and character constants shared by the shell line tokenizer modules.
package slt_pkg;

   // Character codes the lexer recognizes.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   // Lexer mode; the unused code behaves as idle.
   typedef enum logic [1:0] {
      LEX_IDLE  = 2'd0,
      LEX_WORD  = 2'd1,
      LEX_QUOTE = 2'd2
   } lex_mode_type;

   // Single operator byte that a repeat of itself would pair with.
   typedef enum logic [1:0] {
      PAIR_NONE = 2'd0,
      PAIR_BAR  = 2'd1,
      PAIR_AMP  = 2'd2,
      PAIR_SEMI = 2'd3
   } pair_type;

   typedef enum logic [1:0] {
      KIND_WORD = 2'd0,
      KIND_OP   = 2'd1,
      KIND_END  = 2'd2
   } token_kind_type;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_REDIR = 2'd1,
      FAULT_QUOTE = 2'd2
   } fault_type;

   // Lexer state carried from one byte to the next.
   typedef struct packed {
      lex_mode_type mode;
      pair_type     pend;
   } lex_state_type;

   // Classification of one byte.
   typedef struct packed {
      logic [7:0]     byte_out;
      logic           kept;
      logic           token_start;
      token_kind_type token_kind;
      fault_type      fault;
   } lex_result_type;

endpackage

// File: rtl/slt_classify.sv
// Combinational lexer step: classifies one byte and computes the next lexer state.
module slt_classify
   import slt_pkg::*;
(
   input  logic [7:0]     byte_in,
   input  lex_state_type  state_cur,
   output lex_state_type  state_nxt,
   output lex_result_type result
);

   logic     is_white;
   logic     is_redir;
   logic     is_op;
   logic     is_meta;
   pair_type pair_code;

   // Character classes.
   assign is_white = (byte_in == CH_SPACE) || (byte_in == CH_TAB);
   assign is_redir = (byte_in == CH_LT) || (byte_in == CH_GT);
   assign is_op    = (byte_in == CH_BAR) || (byte_in == CH_AMP) || (byte_in == CH_SEMI) ||
                     (byte_in == CH_LPAREN) || (byte_in == CH_RPAREN) || (byte_in == CH_NL);
   assign is_meta  = is_white || is_redir || (byte_in == CH_BAR) || (byte_in == CH_AMP) ||
                     (byte_in == CH_SEMI) || (byte_in == CH_LPAREN) || (byte_in == CH_RPAREN);

   // Operator bytes that can pair with a repeat of themselves.
   always_comb begin
      priority if (byte_in == CH_BAR) begin
         pair_code = PAIR_BAR;
      end else if (byte_in == CH_AMP) begin
         pair_code = PAIR_AMP;
      end else if (byte_in == CH_SEMI) begin
         pair_code = PAIR_SEMI;
      end else begin
         pair_code = PAIR_NONE;
      end
   end

   // Mode update and classification; order of the tests decides.
   always_comb begin
      state_nxt          = state_cur;
      result.byte_out    = byte_in;
      result.kept        = 1'b1;
      result.token_start = 1'b0;
      result.token_kind  = KIND_WORD;
      result.fault       = FAULT_NONE;

      priority if (byte_in == CH_NUL) begin
         // End of line closes everything and flags an open quote.
         result.token_start = 1'b1;
         result.token_kind  = KIND_END;
         result.fault       = (state_cur.mode == LEX_QUOTE) ? FAULT_QUOTE : FAULT_NONE;
         state_nxt.mode     = LEX_IDLE;
         state_nxt.pend     = PAIR_NONE;
      end else if (state_cur.mode == LEX_QUOTE) begin
         // Everything up to the closing quote is part of the word.
         if (byte_in == CH_QUOTE) begin
            state_nxt.mode = LEX_IDLE;
         end
      end else if ((state_cur.mode == LEX_WORD) && !is_meta) begin
         // Plain word continues.
      end else begin
         // Between tokens.
         state_nxt.mode = LEX_IDLE;
         state_nxt.pend = PAIR_NONE;
         priority if ((state_cur.pend != PAIR_NONE) && (pair_code == state_cur.pend)) begin
            result.token_kind = KIND_OP;
         end else if (is_white) begin
            result.kept = 1'b0;
         end else if (is_redir) begin
            result.kept  = 1'b0;
            result.fault = FAULT_REDIR;
         end else if (is_op) begin
            result.token_start = 1'b1;
            result.token_kind  = KIND_OP;
            state_nxt.pend     = pair_code;
         end else begin
            result.token_start = 1'b1;
            state_nxt.mode     = (byte_in == CH_QUOTE) ? LEX_QUOTE : LEX_WORD;
         end
      end
   end

endmodule

// File: rtl/shell_line_tokenizer.sv
// Top level of the shell line tokenizer: input register, lexer step, result register.
//
// Usage: the req channel carries one command-line byte per beat on req_byte_in;
// a zero byte ends the line. Each accepted beat yields exactly one rsp beat that
// echoes the byte and marks it as dropped, starting a token or continuing one,
// with its token kind and any fault.
// Path: a beat accepted into the input register is classified combinationally
// from it and captured in the result register once that register is free,
// then shown on rsp. Throughput: one byte per cycle while rsp_stall does not
// hold a full result register; the lexer mode is a two-bit register updated by
// a short compare network as each byte leaves the input register.
// Stall: when rsp_stall holds the result register full and the input register
// is also full, req_stall rises in the same cycle; otherwise a new beat is taken
// while a finished result still waits. Stalled results do not change.
// Reset: synchronous, active high; it empties both registers and returns the
// lexer to idle between tokens with no pending operator.
module shell_line_tokenizer
   import slt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_kept,
   output logic       rsp_token_start,
   output logic [1:0] rsp_token_kind,
   output logic [1:0] rsp_fault
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff;
   lex_result_type rsp_ff;
   lex_result_type rsp_in;
   lex_state_type  state_ff;
   lex_state_type  state_in;
   logic           out_free;
   logic           advance;

   // Handshake: the result register frees up when empty or taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Lexer step on the registered byte.
   slt_classify u_classify (
      .byte_in   (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (rsp_in)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_in;
      end
   end

   // Lexer state advances with each byte that moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: LEX_IDLE, pend: PAIR_NONE};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_out    = rsp_ff.byte_out;
   assign rsp_kept        = rsp_ff.kept;
   assign rsp_token_start = rsp_ff.token_start;
   assign rsp_token_kind  = rsp_ff.token_kind;
   assign rsp_fault       = rsp_ff.fault;

endmodule

// File: tb/shell_line_tokenizer_tb.sv
// Self-checking testbench for the shell line tokenizer: byte stream in, per-byte classification out.
module shell_line_tokenizer_tb;
   import slt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;
   localparam int TAIL_CYCLES = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_byte_out;
   logic       rsp_kept;
   logic       rsp_token_start;
   logic [1:0] rsp_token_kind;
   logic [1:0] rsp_fault;

   // Bytes waiting to be offered, and classifications waiting to come back.
   logic [7:0]     line_bytes_q[$];
   lex_result_type byte_class_q[$];
   int             bytes_queued = 0;
   int             mismatches = 0;

   // Idle rates in percent, set per phase.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // A toggle of hold_go asks the receiver for one long hold-off.
   bit hold_go = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;

   int quiet_cycles = 0;

   // Lexer state of the predictor.
   lex_mode_type tok_mode = LEX_IDLE;
   pair_type     tok_pend = PAIR_NONE;

   shell_line_tokenizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_kept        (rsp_kept),
      .rsp_token_start (rsp_token_start),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_fault       (rsp_fault)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic bit is_white(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB;
   endfunction

   function automatic bit is_meta(input logic [7:0] b);
      return b == CH_BAR || b == CH_AMP || b == CH_SEMI || b == CH_LPAREN ||
             b == CH_RPAREN || b == CH_LT || b == CH_GT || is_white(b);
   endfunction

   function automatic pair_type pair_of(input logic [7:0] b);
      case (b)
         CH_BAR:  return PAIR_BAR;
         CH_AMP:  return PAIR_AMP;
         CH_SEMI: return PAIR_SEMI;
         default: return PAIR_NONE;
      endcase
   endfunction

   // Classifies one byte and advances the predictor's lexer state.
   function automatic lex_result_type classify_byte(input logic [7:0] b);
      lex_result_type r;
      pair_type       held;
      held = tok_pend;
      r = '{byte_out: b, kept: 1'b1, token_start: 1'b0, token_kind: KIND_WORD,
            fault: FAULT_NONE};
      // End of line closes everything and flags a quote left open.
      if (b == CH_NUL) begin
         r.token_start = 1'b1;
         r.token_kind = KIND_END;
         r.fault = (tok_mode == LEX_QUOTE) ? FAULT_QUOTE : FAULT_NONE;
         tok_mode = LEX_IDLE;
         tok_pend = PAIR_NONE;
         return r;
      end
      // Inside quotes every byte is part of the word; a quote closes it.
      if (tok_mode == LEX_QUOTE) begin
         if (b == CH_QUOTE) begin
            tok_mode = LEX_IDLE;
         end
         return r;
      end
      if (tok_mode == LEX_WORD && !is_meta(b)) begin
         return r;
      end
      // Between tokens from here on.
      tok_mode = LEX_IDLE;
      tok_pend = PAIR_NONE;
      if (held != PAIR_NONE && pair_of(b) == held) begin
         r.token_kind = KIND_OP;
      end else if (is_white(b)) begin
         r.kept = 1'b0;
      end else if (b == CH_LT || b == CH_GT) begin
         r.kept = 1'b0;
         r.fault = FAULT_REDIR;
      end else if (pair_of(b) != PAIR_NONE || b == CH_LPAREN || b == CH_RPAREN ||
                   b == CH_NL) begin
         r.token_start = 1'b1;
         r.token_kind = KIND_OP;
         tok_pend = pair_of(b);
      end else begin
         r.token_start = 1'b1;
         tok_mode = (b == CH_QUOTE) ? LEX_QUOTE : LEX_WORD;
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic put_byte(input logic [7:0] b);
      line_bytes_q.push_back(b);
      bytes_queued++;
   endtask

   // Waits until every queued byte is accepted and every result has come back.
   task automatic drain();
      do begin
         @(negedge clock);
      end while (line_bytes_q.size() != 0 || req_valid || byte_class_q.size() != 0);
   endtask

   // Queues mostly well-formed command lines with random content, plus some noise.
   task automatic fill_lines(input int count);
      int         goal;
      int         ntok;
      int         len;
      logic [7:0] b;
      goal = bytes_queued + count;
      while (bytes_queued < goal) begin
         if ($urandom_range(7) == 0) begin
            // Noise: any byte at all, zero included.
            len = $urandom_range(1, 12);
            repeat (len) put_byte(8'($urandom_range(255)));
         end else begin
            ntok = $urandom_range(1, 6);
            repeat (ntok) begin
               case ($urandom_range(9))
                  0, 1, 2, 3: begin
                     len = $urandom_range(1, 5);
                     repeat (len) begin
                        do b = 8'($urandom_range(1, 255)); while (is_meta(b));
                        put_byte(b);
                     end
                  end
                  4: begin
                     put_byte(CH_QUOTE);
                     len = $urandom_range(0, 4);
                     repeat (len) begin
                        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
                        put_byte(b);
                     end
                     if ($urandom_range(9) != 0) put_byte(CH_QUOTE);
                  end
                  5, 6: begin
                     case ($urandom_range(5))
                        0: b = CH_BAR;
                        1: b = CH_AMP;
                        2: b = CH_SEMI;
                        3: b = CH_LPAREN;
                        4: b = CH_RPAREN;
                        default: b = CH_NL;
                     endcase
                     len = (pair_of(b) != PAIR_NONE) ? $urandom_range(1, 3) : 1;
                     repeat (len) put_byte(b);
                  end
                  7: begin
                     len = $urandom_range(1, 3);
                     repeat (len) put_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
                  end
                  8: put_byte($urandom_range(1) ? CH_LT : CH_GT);
                  default: put_byte(8'($urandom_range(1, 255)));
               endcase
               if ($urandom_range(1)) put_byte(CH_SPACE);
            end
            put_byte(CH_NUL);
         end
      end
   endtask

   // Sender: offers the next byte unless it idles; a stalled beat is held.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_byte_in <= 8'h00;
      end else if (!req_valid || !req_stall) begin
         if (line_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_byte_in <= line_bytes_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, or one long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= hold_go;
      end else if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor: predicts each accepted byte, then checks each accepted result beat.
   always @(posedge clock) begin : monitor
      lex_result_type want;
      if (reset) begin
         tok_mode = LEX_IDLE;
         tok_pend = PAIR_NONE;
      end else begin
         if (req_valid && !req_stall) begin
            byte_class_q.push_back(classify_byte(req_byte_in));
         end
         if (rsp_valid && !rsp_stall) begin
            if (byte_class_q.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual byte %0h",
                        $time, rsp_byte_out);
               mismatches++;
            end else begin
               want = byte_class_q.pop_front();
               check_field("byte_out", want.byte_out, rsp_byte_out);
               check_field("kept", 8'(want.kept), 8'(rsp_kept));
               check_field("token_start", 8'(want.token_start), 8'(rsp_token_start));
               check_field("token_kind", 8'(want.token_kind), 8'(rsp_token_kind));
               check_field("fault", 8'(want.fault), 8'(rsp_fault));
            end
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      string directed;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed line: extreme bytes, quote and newline inside a word, redirection
      // ending a word, a triple bar, paired operators, parentheses, a word right
      // after a closing quote, and a quote left open at end of line.
      directed = "'\n>c|||&&;;()'x y'z\t<'";
      put_byte(8'hFF);
      put_byte(8'h01);
      foreach (directed[i]) put_byte(directed[i]);
      put_byte(CH_NUL);
      drain();

      send_idle_pct = 34;
      recv_stall_pct = 58;
      fill_lines(230);
      drain();

      send_idle_pct = 58;
      recv_stall_pct = 34;
      fill_lines(230);
      drain();

      // No idling; the receiver holds off while the sender keeps offering bytes.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fill_lines(240);
      hold_go = ~hold_go;
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: shell_line_tokenizer.f
rtl/slt_pkg.sv
rtl/slt_classify.sv
rtl/shell_line_tokenizer.sv
tb/shell_line_tokenizer_tb.sv
